FILE: design/integer_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for integer_to_decimal_ascii
// Clocked property checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define I2DA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared widths, character codes and types of the decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;
    typedef logic [VALUE_W-1:0]                 t_value;

endpackage

`default_nettype wire

FILE: design/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a 64-bit value, unsigned or two's complement, to decimal ASCII.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. It then steps a single
// shift-add-3 unit that forms 20 BCD digits, scans down from the top digit
// past the leading zero digits, gives a '-' for a negative signed value, and
// emits the digits (last character marked by tlast). An output stall holds
// the sign and digit steps. The final character may wait in the output
// register while the next request is accepted.
`default_nettype none

`include "integer_to_decimal_ascii_assert.svh"

module integer_to_decimal_ascii (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [63:0] s_axis_tdata,   // [63:0] value
    input  wire [0:0]  s_axis_tuser,   // [0] is_signed
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] character
    output logic       m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                     r_state, n_state;
    logic [i2da_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [i2da_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                           r_neg, n_neg;
    i2da_pkg::t_bcd                 r_bcd, n_bcd;
    i2da_pkg::t_value               r_bin, n_bin;
    logic                           r_oval, n_oval;
    logic [7:0]                     r_odata, n_odata;
    logic                           r_olast, n_olast;

    i2da_pkg::t_bcd                 step_bcd;
    i2da_pkg::t_value               step_bin;
    logic [i2da_pkg::DIGIT_W-1:0]   cur_digit;
    logic                           slot_free;
    logic                           in_neg;

    i2da_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (step_bcd),
        .o_bin (step_bin)
    );

    assign cur_digit     = r_bcd[r_idx];
    assign slot_free     = !r_oval || m_axis_tready;
    assign in_neg        = s_axis_tuser[0] && s_axis_tdata[63];
    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_bcd   = r_bcd;
        n_bin   = r_bin;
        n_oval  = r_oval && !m_axis_tready;
        n_odata = r_odata;
        n_olast = r_olast;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_neg   = in_neg;
                    n_bin   = in_neg ? (~s_axis_tdata + 64'd1) : s_axis_tdata;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = step_bcd;
                n_bin = step_bin;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == i2da_pkg::CNT_W'(i2da_pkg::VALUE_W - 1)) begin
                    n_idx   = i2da_pkg::IDX_W'(i2da_pkg::NUM_DIGITS - 1);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((cur_digit == '0) && (r_idx != '0)) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_oval  = 1'b1;
                    n_odata = i2da_pkg::CHAR_MINUS;
                    n_olast = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_oval  = 1'b1;
                    n_odata = i2da_pkg::CHAR_ZERO + {4'd0, cur_digit};
                    n_olast = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
        r_neg   <= n_neg;
        r_bcd   <= n_bcd;
        r_bin   <= n_bin;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    `I2DA_ASSERT_NOW(a_sign_only_neg, r_state == ST_SIGN, r_neg, "sign state without negative value")
    `I2DA_ASSERT_NOW(a_minus_not_last, m_axis_tvalid && (m_axis_tdata == i2da_pkg::CHAR_MINUS), !m_axis_tlast, "minus marked last")
    `I2DA_ASSERT_NEXT(a_final_digit, (r_state == ST_EMIT) && slot_free && (r_idx == '0), m_axis_tvalid && m_axis_tlast && (r_state == ST_IDLE), "final digit not marked last")

endmodule

`default_nettype wire

FILE: design/i2da_dabble.sv
// ----------------------------------------------------------------------------
// i2da_dabble
// One shift-add-3 step: correct every BCD digit of five or more, then shift
// the BCD and binary words left by one bit together.
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_dabble (
    input  wire i2da_pkg::t_bcd   i_bcd,
    input  wire i2da_pkg::t_value i_bin,
    output i2da_pkg::t_bcd        o_bcd,
    output i2da_pkg::t_value      o_bin
);

    i2da_pkg::t_bcd adj;

    genvar g;
    generate
        for (g = 0; g < i2da_pkg::NUM_DIGITS; g++) begin : g_digit
            assign adj[g] = (i_bcd[g] >= 4'd5) ? (i_bcd[g] + 4'd3) : i_bcd[g];
        end
    endgenerate

    assign o_bcd = {adj[i2da_pkg::NUM_DIGITS-1][i2da_pkg::DIGIT_W-2:0],
                    adj[i2da_pkg::NUM_DIGITS-2:0],
                    i_bin[i2da_pkg::VALUE_W-1]};
    assign o_bin = {i_bin[i2da_pkg::VALUE_W-2:0], 1'b0};

endmodule

`default_nettype wire

FILE: bench/integer_to_decimal_ascii_check.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_check
// Watches both stream channels of the decimal ASCII converter. Every accepted
// request is turned into its expected text. Every accepted character is
// compared with the oldest expected character and its tlast flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_decimal_ascii_check (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    input  wire        s_axis_tready,
    input  wire [63:0] s_axis_tdata,   // [63:0] value
    input  wire [0:0]  s_axis_tuser,   // [0] is_signed
    input  wire        m_axis_tvalid,
    input  wire        m_axis_tready,
    input  wire [7:0]  m_axis_tdata,   // [7:0] character
    input  wire        m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending
);

    localparam i2da_pkg::t_value RADIX = 64'd10;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_char;

    t_text_char expected_text[$];
    t_text_char oldest;
    int         fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_text.size();

    task automatic queue_decimal_text(input i2da_pkg::t_value value, input logic is_signed);
        i2da_pkg::t_value magnitude;
        logic [7:0]       digits[$];
        logic             negative;
        negative  = is_signed && value[i2da_pkg::VALUE_W-1];
        magnitude = negative ? (~value + 64'd1) : value;
        do begin
            digits.push_front(i2da_pkg::CHAR_ZERO + 8'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        if (negative) begin
            expected_text.push_back('{character: i2da_pkg::CHAR_MINUS, last: 1'b0});
        end
        foreach (digits[k]) begin
            expected_text.push_back('{character: digits[k],
                                      last: (k == digits.size() - 1)});
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_text.size() == 0) begin
                    $error("character: expected none, actual %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    oldest = expected_text.pop_front();
                    if (m_axis_tdata !== oldest.character) begin
                        $error("character: expected %h, actual %h",
                               oldest.character, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== oldest.last) begin
                        $error("last: expected %b, actual %b", oldest.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                queue_decimal_text(s_axis_tdata, s_axis_tuser[0]);
            end
        end
    end

endmodule

FILE: bench/integer_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_test
// Drives directed and random numbers, signed and unsigned, into the decimal
// ASCII converter with random gaps and output stalls, and gives the verdict
// from the checker's failure count and leftover expectations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_decimal_ascii_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_PERCENT = 33;

    typedef struct {
        i2da_pkg::t_value value;
        logic             is_signed;
    } t_number_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [63:0] value
    logic [0:0]  s_axis_tuser;   // [0] is_signed
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] character
    logic        m_axis_tlast;
    logic        calm;
    int          fail_count;
    int          pending;
    int          cycles = 0;

    t_number_req numbers[$];

    integer_to_decimal_ascii uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    integer_to_decimal_ascii_check checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("integer_to_decimal_ascii regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    function automatic i2da_pkg::t_value power_of_ten(input int exponent);
        i2da_pkg::t_value p;
        p = 64'd1;
        for (int k = 0; k < exponent; k++) p = p * 64'd10;
        return p;
    endfunction

    task automatic add_number(input i2da_pkg::t_value value, input logic is_signed);
        numbers.push_back('{value: value, is_signed: is_signed});
    endtask

    task automatic build_numbers();
        i2da_pkg::t_value raw;
        int               pick;
        add_number(64'd0, 1'b0);
        add_number(64'd0, 1'b1);
        add_number(64'd1, 1'b0);
        add_number({64{1'b1}}, 1'b1);
        add_number({64{1'b1}}, 1'b0);
        add_number({1'b1, 63'd0}, 1'b1);
        add_number({1'b1, 63'd0}, 1'b0);
        add_number({1'b0, {63{1'b1}}}, 1'b1);
        add_number({1'b1, 62'd0, 1'b1}, 1'b1);
        add_number(64'd9, 1'b1);
        add_number(64'd10, 1'b0);
        add_number(64'd99, 1'b1);
        add_number(64'd100, 1'b0);
        add_number(power_of_ten(19), 1'b0);
        add_number(power_of_ten(19) - 64'd1, 1'b0);
        add_number(power_of_ten(18), 1'b1);
        add_number(-64'sd10, 1'b1);
        add_number(-64'sd10, 1'b0);
        add_number(64'h0123_4567_89ab_cdef, 1'b1);
        add_number(64'hfedc_ba98_7654_3210, 1'b1);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            raw  = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: begin
                    add_number(raw, 1'($urandom_range(0, 1)));
                end
                3, 4, 5: begin
                    add_number(raw >> $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                end
                6, 7: begin
                    add_number(-(raw >> $urandom_range(1, 63)), 1'b1);
                end
                default: begin
                    add_number(power_of_ten($urandom_range(0, 19))
                               + 64'($signed($urandom_range(0, 2)) - 1),
                               1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    initial begin
        int idx;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        calm          <= 1'b0;
        build_numbers();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idx = 0;
        while (idx < numbers.size()) begin
            @(posedge i_clk);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_axis_tvalid) idx++;
                calm <= (idx >= 40 && idx < 75);
                if (idx == numbers.size()) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= numbers[idx].value;
                    s_axis_tuser  <= numbers[idx].is_signed;
                end
            end
        end
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("integer_to_decimal_ascii regression: pass");
        end else begin
            $display("integer_to_decimal_ascii regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/i2da_pkg.sv
design/i2da_dabble.sv
design/integer_to_decimal_ascii.sv
bench/integer_to_decimal_ascii_check.sv
bench/integer_to_decimal_ascii_test.sv
